// ===== design/packed_quaternion_decoder_assert.svh =====
// Assertion macros shared by the packed quaternion decoder RTL.
`ifndef PACKED_QUATERNION_DECODER_ASSERT_SVH
`define PACKED_QUATERNION_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PQD_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pqd_pkg.sv =====
// Shared constants and types for the packed quaternion decoder.
`default_nettype none

package pqd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 48;
  localparam int CODE_W        = 15;
  localparam int NUM_CODES     = 3;
  localparam int IDX_W         = 2;
  localparam int SCALE_W       = 32;
  localparam int OUT_W         = 18;

  localparam int CODE_A_LSB = 32;
  localparam int CODE_B_LSB = 17;
  localparam int CODE_C_LSB = 2;

  localparam logic [CODE_W-1:0]  CODE_BIAS = 15'd16383;
  // 0.707107 in Q0.32, rounded to nearest
  localparam logic [SCALE_W-1:0] SCALE_Q32 = 32'd3037001440;

  localparam int               OUT_MAX      = 131071;
  localparam int               OUT_MIN_MAG  = 131072;
  localparam logic [OUT_W-1:0] OUT_MAX_CODE = 18'h1FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN_CODE = 18'h20000;

  // position of the omitted (largest) element
  localparam logic [IDX_W-1:0] IDX_Q0 = 2'd0;
  localparam logic [IDX_W-1:0] IDX_Q1 = 2'd1;
  localparam logic [IDX_W-1:0] IDX_Q2 = 2'd2;
  localparam logic [IDX_W-1:0] IDX_Q3 = 2'd3;

  typedef struct packed {
    logic                 vld;
    logic [IDX_W-1:0]     idx;
    logic [NUM_CODES-1:0] neg;
    logic                 clamped;
  } pqd_ctl_t;

endpackage

`default_nettype wire

// ===== design/pqd_decode.sv =====
// Code unpacking, scale multiply and rounding (two stages).
`default_nettype none

module pqd_decode #(
  parameter int FRAC_BITS = pqd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         en,
  input  wire logic                                         vld_i,
  input  wire logic [pqd_pkg::WORD_W-1:0]                   word_i,
  output pqd_pkg::pqd_ctl_t                                 ctl_o,
  output logic      [pqd_pkg::NUM_CODES-1:0][FRAC_BITS-1:0] mag_o
);
  import pqd_pkg::*;

  localparam int SHIFT  = 46 - FRAC_BITS;
  localparam int MAG_W  = FRAC_BITS;
  localparam int PROD_W = CODE_W + SCALE_W;
  localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (SHIFT - 1);

  logic [NUM_CODES-1:0][CODE_W-1:0] code;
  logic [NUM_CODES-1:0][CODE_W-1:0] dmag;
  logic [NUM_CODES-1:0]             neg_n;
  logic [NUM_CODES-1:0][PROD_W-1:0] prod_next;
  logic [NUM_CODES-1:0][PROD_W:0]   rsum;

  pqd_ctl_t                         ctl1;
  logic [NUM_CODES-1:0][PROD_W-1:0] prod;

  assign code[0] = word_i[CODE_A_LSB +: CODE_W];
  assign code[1] = word_i[CODE_B_LSB +: CODE_W];
  assign code[2] = word_i[CODE_C_LSB +: CODE_W];

  // |code - bias| fits 15 bits (max 16384)
  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      neg_n[i]     = code[i] < CODE_BIAS;
      dmag[i]      = neg_n[i] ? (CODE_BIAS - code[i]) : (code[i] - CODE_BIAS);
      prod_next[i] = PROD_W'(dmag[i]) * PROD_W'(SCALE_Q32);
      rsum[i]      = {1'b0, prod[i]} + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.vld  <= 1'b0;
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl1.vld     <= vld_i;
      ctl1.idx     <= word_i[IDX_W-1:0];
      ctl1.neg     <= neg_n;
      ctl1.clamped <= 1'b0;
      prod         <= prod_next;
      ctl_o        <= ctl1;
      for (int i = 0; i < NUM_CODES; i++) begin
        mag_o[i] <= rsum[i][SHIFT +: MAG_W];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pqd_square_sum.sv =====
// Squares of the three magnitudes, then sum and radicand with clamp (two stages).
`default_nettype none

module pqd_square_sum #(
  parameter int FRAC_BITS = pqd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         en,
  input  pqd_pkg::pqd_ctl_t                                 ctl_i,
  input  wire logic [pqd_pkg::NUM_CODES-1:0][FRAC_BITS-1:0] mag_i,
  output pqd_pkg::pqd_ctl_t                                 ctl_o,
  output logic      [pqd_pkg::NUM_CODES-1:0][FRAC_BITS-1:0] mag_o,
  output logic      [2*FRAC_BITS+1:0]                       rad_o
);
  import pqd_pkg::*;

  localparam int MAG_W = FRAC_BITS;
  localparam int SQ_W  = 2 * FRAC_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << SQ_W;

  pqd_ctl_t                        ctl_c;
  pqd_ctl_t                        ctl_next;
  logic [NUM_CODES-1:0][MAG_W-1:0] mag_c;
  logic [NUM_CODES-1:0][SQ_W-1:0]  sq;
  logic [SUM_W-1:0]                sum;
  logic                            over;

  assign sum  = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  assign over = sum > ONE;

  // control word with the clamp flag filled in
  always_comb begin
    ctl_next         = ctl_c;
    ctl_next.clamped = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c.vld <= 1'b0;
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl_c <= ctl_i;
      mag_c <= mag_i;
      for (int i = 0; i < NUM_CODES; i++) begin
        sq[i] <= SQ_W'(mag_i[i]) * SQ_W'(mag_i[i]);
      end
      ctl_o <= ctl_next;
      mag_o <= mag_c;
      rad_o <= over ? '0 : (ONE - sum);
    end
  end

endmodule

`default_nettype wire

// ===== design/pqd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per pipeline stage.
`default_nettype none

module pqd_sqrt #(
  parameter int FRAC_BITS = pqd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         en,
  input  pqd_pkg::pqd_ctl_t                                 ctl_i,
  input  wire logic [pqd_pkg::NUM_CODES-1:0][FRAC_BITS-1:0] mag_i,
  input  wire logic [2*FRAC_BITS+1:0]                       rad_i,
  output pqd_pkg::pqd_ctl_t                                 ctl_o,
  output logic      [pqd_pkg::NUM_CODES-1:0][FRAC_BITS-1:0] mag_o,
  output logic      [FRAC_BITS:0]                           root_o,
  output logic      [FRAC_BITS+2:0]                         rem_o
);
  import pqd_pkg::*;

  localparam int MAG_W = FRAC_BITS;
  localparam int N     = FRAC_BITS + 1;   // root bits = stages
  localparam int RAD_W = 2 * N;
  localparam int REM_W = N + 2;
  localparam int TRY_W = REM_W + 2;

  pqd_ctl_t                        ctl_q  [N];
  logic [NUM_CODES-1:0][MAG_W-1:0] mag_q  [N];
  logic [RAD_W-1:0]                rad_q  [N];
  logic [REM_W-1:0]                rem_q  [N];
  logic [N-1:0]                    root_q [N];

  logic [RAD_W-1:0] src_rad  [N];
  logic [REM_W-1:0] src_rem  [N];
  logic [N-1:0]     src_root [N];
  logic [TRY_W-1:0] trial    [N];
  logic [TRY_W-1:0] tgt      [N];
  logic [TRY_W-1:0] diff     [N];
  logic [N-1:0]     ge;

  always_comb begin
    src_rad[0]  = rad_i;
    src_rem[0]  = '0;
    src_root[0] = '0;
    for (int k = 1; k < N; k++) begin
      src_rad[k]  = rad_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_root[k] = root_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = {src_rem[k], src_rad[k][RAD_W-1 -: 2]};
      tgt[k]   = {{(TRY_W-N-2){1'b0}}, src_root[k], 2'b01};
      diff[k]  = trial[k] - tgt[k];
      ge[k]    = trial[k] >= tgt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        ctl_q[k].vld <= 1'b0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_i;
      mag_q[0] <= mag_i;
      for (int k = 1; k < N; k++) begin
        ctl_q[k] <= ctl_q[k-1];
        mag_q[k] <= mag_q[k-1];
      end
      for (int k = 0; k < N; k++) begin
        rad_q[k]  <= {src_rad[k][RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge[k] ? diff[k][REM_W-1:0] : trial[k][REM_W-1:0];
        root_q[k] <= {src_root[k][N-2:0], ge[k]};
      end
    end
  end

  assign ctl_o  = ctl_q[N-1];
  assign mag_o  = mag_q[N-1];
  assign root_o = root_q[N-1];
  assign rem_o  = rem_q[N-1];

endmodule

`default_nettype wire

// ===== design/packed_quaternion_decoder.sv =====
// Top level: input skid, decode pipeline, root rounding and output register.
//
// Packed quaternion decoder (smallest-three, 15-bit codes).
// Input channel: packed_word with word_valid / word_stall. One item is taken
//   at a clock edge where word_valid is high and word_stall is low.
// Output channel: component_0..3 and radicand_clamped with quat_valid /
//   quat_stall. One result item per input item, in order.
// Throughput: one item per cycle sustained, limited by nothing but the
//   handshakes; every stage is registered and the root is one bit a stage.
// Registers: FRAC_BITS+6 in the path to quat_valid: 2 decode, 2 square/sum,
//   FRAC_BITS+1 root, 1 output.
// Stall: a stall on the output freezes the whole pipeline. word_stall comes
//   from a one-entry skid register, so it is a flop output and the item that
//   arrives in the freeze cycle is held there, not lost.
// Reset (rst, synchronous): clears all valid bits and the skid; no item is
//   in flight afterwards. The pad bit (bit 47) is ignored.
`default_nettype none

module packed_quaternion_decoder #(
  parameter int FRAC_BITS = pqd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                word_valid,
  output logic                                     word_stall,
  input  wire logic [pqd_pkg::WORD_W-1:0]          packed_word,
  output logic                                     quat_valid,
  input  wire logic                                quat_stall,
  output logic signed [pqd_pkg::OUT_W-1:0]         component_0,
  output logic signed [pqd_pkg::OUT_W-1:0]         component_1,
  output logic signed [pqd_pkg::OUT_W-1:0]         component_2,
  output logic signed [pqd_pkg::OUT_W-1:0]         component_3,
  output logic                                     radicand_clamped
);
  import pqd_pkg::*;

  localparam int MAG_W  = FRAC_BITS;
  localparam int ROOT_W = FRAC_BITS + 1;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int CMP_W  = ((MAG_W + 1 > OUT_W) ? MAG_W + 1 : OUT_W) + 1;
  localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1) << FRAC_BITS;

  // whole pipeline moves unless a finished result is being held back
  logic adv;
  assign adv = !quat_valid || !quat_stall;

  // skid: catches the item offered in a frozen cycle
  logic              skid_vld;
  logic [WORD_W-1:0] skid_word;
  logic              src_vld;
  logic [WORD_W-1:0] src_word;

  assign word_stall = skid_vld;
  assign src_vld    = skid_vld || word_valid;
  assign src_word   = skid_vld ? skid_word : packed_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (adv) begin
      skid_vld <= 1'b0;
    end else if (word_valid && !skid_vld) begin
      skid_vld  <= 1'b1;
      skid_word <= packed_word;
    end
  end

  pqd_ctl_t                        dec_ctl;
  logic [NUM_CODES-1:0][MAG_W-1:0] dec_mag;
  pqd_ctl_t                        sum_ctl;
  logic [NUM_CODES-1:0][MAG_W-1:0] sum_mag;
  logic [RAD_W-1:0]                sum_rad;
  pqd_ctl_t                        sq_ctl;
  logic [NUM_CODES-1:0][MAG_W-1:0] sq_mag;
  logic [ROOT_W-1:0]               sq_root;
  logic [REM_W-1:0]                sq_rem;

  pqd_decode #(.FRAC_BITS(FRAC_BITS)) u_decode (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_i  (src_vld),
    .word_i (src_word),
    .ctl_o  (dec_ctl),
    .mag_o  (dec_mag)
  );

  pqd_square_sum #(.FRAC_BITS(FRAC_BITS)) u_square_sum (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .ctl_i (dec_ctl),
    .mag_i (dec_mag),
    .ctl_o (sum_ctl),
    .mag_o (sum_mag),
    .rad_o (sum_rad)
  );

  pqd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .ctl_i  (sum_ctl),
    .mag_i  (sum_mag),
    .rad_i  (sum_rad),
    .ctl_o  (sq_ctl),
    .mag_o  (sq_mag),
    .root_o (sq_root),
    .rem_o  (sq_rem)
  );

  // sign-magnitude to 18-bit two's complement, saturating
  function automatic logic [OUT_W-1:0] saturate(input logic [CMP_W-1:0] m,
                                                input logic neg);
    logic [OUT_W-1:0] r;
    if (!neg) begin
      r = (m > CMP_W'(OUT_MAX)) ? OUT_MAX_CODE : m[OUT_W-1:0];
    end else begin
      r = (m > CMP_W'(OUT_MIN_MAG)) ? OUT_MIN_CODE : (~m[OUT_W-1:0] + 1'b1);
    end
    return r;
  endfunction

  // round root to nearest: bump when remainder exceeds root
  logic [ROOT_W:0]              root_rnd;
  logic [OUT_W-1:0]             root_out;
  logic [NUM_CODES-1:0][OUT_W-1:0] val_out;
  logic [OUT_W-1:0]             q0_next;
  logic [OUT_W-1:0]             q1_next;
  logic [OUT_W-1:0]             q2_next;
  logic [OUT_W-1:0]             q3_next;

  assign root_rnd = (ROOT_W+1)'(sq_root)
                  + (ROOT_W+1)'(sq_rem > REM_W'(sq_root));
  assign root_out = saturate(CMP_W'(root_rnd), 1'b0);

  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      val_out[i] = saturate(CMP_W'(sq_mag[i]), sq_ctl.neg[i]);
    end
  end

  // omitted element takes the root; decoded values fill the rest in order
  always_comb begin
    unique case (sq_ctl.idx)
      IDX_Q0: begin
        q0_next = root_out;   q1_next = val_out[0];
        q2_next = val_out[1]; q3_next = val_out[2];
      end
      IDX_Q1: begin
        q0_next = val_out[0]; q1_next = root_out;
        q2_next = val_out[1]; q3_next = val_out[2];
      end
      IDX_Q2: begin
        q0_next = val_out[0]; q1_next = val_out[1];
        q2_next = root_out;   q3_next = val_out[2];
      end
      IDX_Q3: begin
        q0_next = val_out[0]; q1_next = val_out[1];
        q2_next = val_out[2]; q3_next = root_out;
      end
    endcase
  end

  // output register: holds while stalled since adv is low
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (adv) begin
      quat_valid       <= sq_ctl.vld;
      component_0      <= $signed(q0_next);
      component_1      <= $signed(q1_next);
      component_2      <= $signed(q2_next);
      component_3      <= $signed(q3_next);
      radicand_clamped <= sq_ctl.clamped;
    end
  end

  `include "packed_quaternion_decoder_assert.svh"

  `PQD_ASSERT_HOLDS(a_clamp_zero_root, sq_ctl.vld && sq_ctl.clamped, sq_root == '0, "root set")
  `PQD_ASSERT_HOLDS(a_root_bound, sq_ctl.vld, sq_root <= ROOT_MAX, "root above one")
  `PQD_ASSERT_HOLDS(a_skid_fill, $rose(skid_vld), !$past(adv), "skid filled while pipeline moving")
  `PQD_ASSERT_NEXT(a_skid_hold, skid_vld && !adv, skid_vld && $stable(skid_word), "skid item lost")

endmodule

`default_nettype wire
